@@ sv/dual_ultrasonic_echo_ranger_assert.svh @@
// ----------------------------------------------------------------------------
// dual_ultrasonic_echo_ranger_assert.svh
// assertion macros used by the ranger checker
// ----------------------------------------------------------------------------
`ifndef DUAL_ULTRASONIC_ECHO_RANGER_ASSERT_SVH
`define DUAL_ULTRASONIC_ECHO_RANGER_ASSERT_SVH

// clocked property, muted while reset is high
`define DURE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property that also holds through reset
`define DURE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/dure_pkg.sv @@
// ----------------------------------------------------------------------------
// dure_pkg
// types and constants of the dual ultrasonic echo ranger
// ----------------------------------------------------------------------------
`default_nettype none

package dure_pkg;

   localparam int unsigned CNT_W = 16;
   localparam int unsigned CFG_W = 16;
   localparam int unsigned CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   localparam logic [CFG_W-1:0] TRIG_RST    = CFG_W'(15);
   localparam logic [CFG_W-1:0] TIMEOUT_RST = CFG_W'(2000);

   // width to centimetres: width * SOUND_NUM / SOUND_DEN, saturated
   localparam int unsigned DIST_W    = 8;
   localparam int unsigned DIST_MAX  = (1 << DIST_W) - 1;
   localparam int unsigned SOUND_NUM = 346;
   localparam int unsigned SOUND_DEN = 20000;
   localparam int unsigned SAT_THR   = ((DIST_MAX + 1) * SOUND_DEN + SOUND_NUM - 1) / SOUND_NUM;
   localparam int unsigned KEEP_W    = $clog2(SAT_THR);
   localparam int unsigned X_W       = $clog2(SAT_THR * SOUND_NUM);
   localparam int unsigned RSH       = X_W + $clog2(SOUND_DEN);
   localparam longint unsigned RECIP = ((64'd1 << RSH) + SOUND_DEN - 1) / SOUND_DEN;
   localparam int unsigned RCP_W     = $clog2(RECIP);
   localparam int unsigned PROD_W    = X_W + RCP_W;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_TRIG,
      PH_MEAS
   } phase_type;

   typedef enum logic {
      REG_TRIGGER,
      REG_TIMEOUT
   } csr_reg_type;

   typedef struct packed {
      logic start_req;
      logic skip_measure;
      logic echo_left;
      logic echo_right;
   } req_type;

   typedef struct packed {
      logic              trigger_out;
      logic              busy_res;
      logic              done_res;
      logic [DIST_W-1:0] distance_left;
      logic [DIST_W-1:0] distance_right;
   } rsp_type;

   typedef struct packed {
      logic             valid;
      csr_reg_type      idx;
      logic [CFG_W-1:0] data;
   } csr_wr_type;

   typedef struct packed {
      logic trigger;
      logic busy;
      logic done;
   } flags_type;

   // one item leaving the controller: status plus per-side pulse width
   typedef struct packed {
      flags_type                  flags;
      logic [1:0]                 ok;
      logic [1:0][CNT_W-1:0]      width;
   } ctrl_item_type;

endpackage

`default_nettype wire

@@ sv/dure_lane.sv @@
// ----------------------------------------------------------------------------
// dure_lane
// two-stage pulse width to centimetre conversion for one sensor side
// ----------------------------------------------------------------------------
`default_nettype none

module dure_lane import dure_pkg::*; (
   input  wire logic              clock,
   input  wire logic              load_a,
   input  wire logic              load_b,
   input  wire logic              ok,
   input  wire logic [CNT_W-1:0]  width,
   output logic      [DIST_W-1:0] cm
);

   logic [X_W-1:0]    x_ff, x_in;
   logic              sat_ff, sat_in;
   logic              zero_ff, zero_in;
   logic [DIST_W-1:0] cm_ff, cm_in;
   logic [KEEP_W-1:0] w_keep;
   logic [PROD_W-1:0] prod;

   // stage a: saturation check and scale by the sound constant
   always_comb begin
      w_keep  = KEEP_W'(width);
      sat_in  = 32'(width) >= SAT_THR;
      zero_in = !ok;
      x_in    = X_W'(w_keep) * X_W'(SOUND_NUM);
   end

   // stage b: divide by reciprocal multiply, exact below the saturation point
   always_comb begin
      prod = PROD_W'(x_ff) * PROD_W'(RECIP);
      priority if (zero_ff) begin
         cm_in = '0;
      end else if (sat_ff) begin
         cm_in = '1;
      end else begin
         cm_in = prod[RSH +: DIST_W];
      end
   end

   always_ff @(posedge clock) begin
      if (load_a) begin
         x_ff    <= x_in;
         sat_ff  <= sat_in;
         zero_ff <= zero_in;
      end
      if (load_b) begin
         cm_ff <= cm_in;
      end
   end

   assign cm = cm_ff;

endmodule

`default_nettype wire

@@ sv/dure_ctrl.sv @@
// ----------------------------------------------------------------------------
// dure_ctrl
// trigger and echo timing sequencer, one tick per accepted item
// ----------------------------------------------------------------------------
`default_nettype none

module dure_ctrl import dure_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire csr_wr_type    csr_wr,
   input  wire logic          accept,
   input  wire req_type       req,
   output ctrl_item_type      item
);

   phase_type                phase_ff, phase_in;
   logic [CNT_W-1:0]         tick_ff, tick_in;
   logic [1:0][CNT_W-1:0]    rise_ff, rise_in;
   logic [1:0][CNT_W-1:0]    fall_ff, fall_in;
   logic [1:0]               rise_seen_ff, rise_seen_in;
   logic [1:0]               fall_seen_ff, fall_seen_in;
   logic [CFG_W-1:0]         trig_len_ff, timeout_ff;
   logic [CFG_W-1:0]         tlen;
   logic [CNT_W-1:0]         tick_inc;
   logic [1:0]               echo;

   always_comb begin
      tlen     = (trig_len_ff == '0) ? CFG_W'(1) : trig_len_ff;
      tick_inc = (tick_ff == CNT_MAX) ? CNT_MAX : tick_ff + CNT_W'(1);
      echo     = {req.echo_right, req.echo_left};

      phase_in     = phase_ff;
      tick_in      = tick_ff;
      rise_in      = rise_ff;
      fall_in      = fall_ff;
      rise_seen_in = rise_seen_ff;
      fall_seen_in = fall_seen_ff;
      item.flags   = '0;
      item.ok      = '0;

      unique case (phase_ff)
         PH_IDLE: begin
            if (req.start_req) begin
               if (req.skip_measure) begin
                  item.flags.done = 1'b1;
               end else begin
                  item.flags.trigger = 1'b1;
                  item.flags.busy    = 1'b1;
                  rise_in            = '0;
                  fall_in            = '0;
                  rise_seen_in       = '0;
                  fall_seen_in       = '0;
                  if (tlen == CFG_W'(1)) begin
                     phase_in = PH_MEAS;
                     tick_in  = '0;
                  end else begin
                     phase_in = PH_TRIG;
                     tick_in  = CNT_W'(1);
                  end
               end
            end
         end
         PH_TRIG: begin
            item.flags.trigger = 1'b1;
            item.flags.busy    = 1'b1;
            tick_in            = tick_inc;
            if (CMP_W'(tick_inc) >= CMP_W'(tlen) || tick_inc == CNT_MAX) begin
               phase_in = PH_MEAS;
               tick_in  = '0;
            end
         end
         PH_MEAS: begin
            for (int s = 0; s < 2; s++) begin
               if (!rise_seen_ff[s]) begin
                  if (echo[s]) begin
                     rise_in[s]      = tick_ff;
                     rise_seen_in[s] = 1'b1;
                  end
               end else if (!fall_seen_ff[s]) begin
                  if (!echo[s]) begin
                     fall_in[s]      = tick_ff;
                     fall_seen_in[s] = 1'b1;
                  end
               end
            end
            priority if (&fall_seen_in) begin
               item.flags.done = 1'b1;
            end else if (CMP_W'(tick_ff) > CMP_W'(timeout_ff) || tick_ff == CNT_MAX) begin
               item.flags.done = 1'b1;
            end else begin
               tick_in         = tick_inc;
               item.flags.busy = 1'b1;
            end
            if (item.flags.done) begin
               phase_in = PH_IDLE;
               item.ok  = rise_seen_in & fall_seen_in;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      for (int s = 0; s < 2; s++) begin
         item.width[s] = fall_in[s] - rise_in[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         tick_ff      <= '0;
         rise_ff      <= '0;
         fall_ff      <= '0;
         rise_seen_ff <= '0;
         fall_seen_ff <= '0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         tick_ff      <= tick_in;
         rise_ff      <= rise_in;
         fall_ff      <= fall_in;
         rise_seen_ff <= rise_seen_in;
         fall_seen_ff <= fall_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_len_ff <= TRIG_RST;
         timeout_ff  <= TIMEOUT_RST;
      end else if (csr_wr.valid) begin
         unique case (csr_wr.idx)
            REG_TRIGGER: trig_len_ff <= csr_wr.data;
            REG_TIMEOUT: timeout_ff  <= csr_wr.data;
         endcase
      end
   end

endmodule

`default_nettype wire

@@ sv/dual_ultrasonic_echo_ranger.sv @@
// Pipeline: an accepted item passes the controller register, two conversion
//   stages in each side lane and the output register before it is shown.
// Throughput: one item per cycle while rsp_ready does not stall the output; the lanes convert both sides in parallel.
// Reset: synchronous, active high; sequencer idle, held distances zero,
//   trigger length 15 and timeout 2000 ticks, pipeline empty.
// ----------------------------------------------------------------------------
// dual_ultrasonic_echo_ranger
// two-channel ultrasonic ranging controller top level
// ----------------------------------------------------------------------------
`default_nettype none

module dual_ultrasonic_echo_ranger import dure_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire req_type          req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rsp_type               rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic             csr_index,
   input  wire logic [CFG_W-1:0] csr_wdata
);

   csr_wr_type          csr_wr;
   ctrl_item_type       item;
   logic                accept;

   logic                s1_valid_ff, s1_valid_in;
   ctrl_item_type       s1_item_ff;
   logic                s2_valid_ff, s2_valid_in;
   flags_type           s2_flags_ff;
   logic                s3_valid_ff, s3_valid_in;
   flags_type           s3_flags_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;
   logic [1:0][DIST_W-1:0] hold_ff, hold_in;
   logic [1:0][DIST_W-1:0] cm;

   logic rdy_out, rdy3, rdy2, rdy1;
   logic load_s2, load_s3, load_out;

   assign csr_ready    = 1'b1;
   assign csr_wr.valid = csr_valid;
   assign csr_wr.idx   = csr_reg_type'(csr_index);
   assign csr_wr.data  = csr_wdata;

   // stage-wise ready so empty stages keep filling behind a held result
   always_comb begin
      rdy_out  = !rsp_valid_ff || rsp_ready;
      rdy3     = !s3_valid_ff || rdy_out;
      rdy2     = !s2_valid_ff || rdy3;
      rdy1     = !s1_valid_ff || rdy2;
      accept   = req_valid && rdy1;
      load_s2  = s1_valid_ff && rdy2;
      load_s3  = s2_valid_ff && rdy3;
      load_out = s3_valid_ff && rdy_out;

      s1_valid_in  = accept   ? 1'b1 : (load_s2  ? 1'b0 : s1_valid_ff);
      s2_valid_in  = load_s2  ? 1'b1 : (load_s3  ? 1'b0 : s2_valid_ff);
      s3_valid_in  = load_s3  ? 1'b1 : (load_out ? 1'b0 : s3_valid_ff);
      rsp_valid_in = load_out ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   assign req_ready = rdy1;

   dure_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .csr_wr (csr_wr),
      .accept (accept),
      .req    (req_data),
      .item   (item)
   );

   for (genvar g = 0; g < 2; g++) begin : g_lane
      dure_lane u_lane (
         .clock  (clock),
         .load_a (load_s2),
         .load_b (load_s3),
         .ok     (s1_item_ff.ok[g]),
         .width  (s1_item_ff.width[g]),
         .cm     (cm[g])
      );
   end

   // merge: a finished measurement replaces the held distances
   always_comb begin
      hold_in = hold_ff;
      if (load_out && s3_flags_ff.done) begin
         hold_in = cm;
      end
      rsp_data_in.trigger_out    = s3_flags_ff.trigger;
      rsp_data_in.busy_res       = s3_flags_ff.busy;
      rsp_data_in.done_res       = s3_flags_ff.done;
      rsp_data_in.distance_left  = hold_in[0];
      rsp_data_in.distance_right = hold_in[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hold_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         hold_ff      <= hold_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= item;
      end
      if (load_s2) begin
         s2_flags_ff <= s1_item_ff.flags;
      end
      if (load_s3) begin
         s3_flags_ff <= s2_flags_ff;
      end
      if (load_out) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

@@ sv/dure_checker.sv @@
// ----------------------------------------------------------------------------
// dure_checker
// port-level assertions for the dual ultrasonic echo ranger
// ----------------------------------------------------------------------------
`default_nettype none

`include "dual_ultrasonic_echo_ranger_assert.svh"

module dure_checker import dure_pkg::*; (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire rsp_type          rsp_data
);

   `DURE_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "result item changed while stalled")

   `DURE_ASSERT(a_done_not_busy, clock, reset, rsp_valid |-> !(rsp_data.done_res && rsp_data.busy_res), "done and busy in the same item")

   `DURE_ASSERT(a_trig_busy, clock, reset, rsp_valid && rsp_data.trigger_out |-> rsp_data.busy_res, "trigger driven outside a measurement")

   `DURE_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result item shown right after reset")

endmodule

bind dual_ultrasonic_echo_ranger dure_checker u_dure_checker (.*);

`default_nettype wire
